>>> src/hgc_pkg.sv
// Shared constants, tables and command types of the Hangul glyph composer.
package hgc_pkg;

  // Store sizes in glyphs; each glyph holds sixteen row words.
  localparam int INITIAL_GLYPHS = 190;
  localparam int MEDIAL_GLYPHS  = 84;
  localparam int FINAL_GLYPHS   = 108;
  localparam int ROWS           = 16;
  localparam int ROW_W          = 4;

  localparam int INIT_DEPTH = INITIAL_GLYPHS * ROWS;
  localparam int MED_DEPTH  = MEDIAL_GLYPHS * ROWS;
  localparam int FIN_DEPTH  = FINAL_GLYPHS * ROWS;

  localparam int INIT_GW = $clog2(INITIAL_GLYPHS);
  localparam int MED_GW  = $clog2(MEDIAL_GLYPHS);
  localparam int FIN_GW  = $clog2(FINAL_GLYPHS);

  localparam int INIT_AW = INIT_GW + ROW_W;
  localparam int MED_AW  = MED_GW + ROW_W;
  localparam int FIN_AW  = FIN_GW + ROW_W;

  // Highest valid jamo codes; anything above reads as no jamo.
  localparam logic [4:0] INIT_CODES = 5'd19;
  localparam logic [4:0] MED_CODES  = 5'd21;
  localparam logic [4:0] FIN_CODES  = 5'd27;

  // Store selector codes of a row write.
  localparam logic [1:0] STORE_INITIAL = 2'd0;
  localparam logic [1:0] STORE_MEDIAL  = 2'd1;
  localparam logic [1:0] STORE_FINAL   = 2'd2;

  // Request kinds carried in the input tuser.
  localparam logic FUNC_WRITE   = 1'b0;
  localparam logic FUNC_COMPOSE = 1'b1;

  localparam logic [4:0] ADV_NARROW = 5'd8;
  localparam logic [4:0] ADV_WIDE   = 5'd16;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;

  // Glyph set of the initial consonant, chosen by the medial vowel.
  function automatic logic [2:0] init_set(input logic [4:0] m);
    logic [2:0] s;
    unique case (m)
      5'd9, 5'd13, 5'd19:         s = 3'd1;
      5'd14, 5'd18:               s = 3'd2;
      5'd10, 5'd11, 5'd12, 5'd20: s = 3'd3;
      5'd15, 5'd16, 5'd17:        s = 3'd4;
      default:                    s = 3'd0;
    endcase
    return s;
  endfunction

  // Glyph set of the final consonant, chosen by the medial vowel.
  function automatic logic [1:0] fin_set(input logic [4:0] m);
    logic [1:0] s;
    unique case (m)
      5'd9, 5'd13, 5'd14, 5'd18, 5'd19: s = 2'd3;
      5'd15, 5'd16, 5'd17:              s = 2'd2;
      default:                          s = 2'd0;
    endcase
    return s;
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             wr_en;    // store one row word from the input request
    logic             cap;      // capture a compose request
    logic             issue;    // read one row from the three stores
    logic [ROW_W-1:0] rd_row;   // row being read
    logic             load;     // move the read row into the output register
    logic [ROW_W-1:0] out_row;  // row number of the data being loaded
  } hgc_cmd_t;

endpackage

>>> src/hgc_ctrl.sv
// Controller of the glyph composer: request acceptance, row sequencing, output flow.
module hgc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  input  logic            s_tuser,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  output hgc_pkg::hgc_cmd_t cmd
);
  import hgc_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic             state;
  logic             state_next;
  logic [ROW_W:0]   issue_cnt;
  logic             dv;
  logic [ROW_W-1:0] dv_row;
  logic             out_valid;
  logic             accept;
  logic             issue;
  logic             load;
  logic             last_load;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign load      = dv && (!out_valid || m_tready);
  assign issue     = (state == ST_RUN) && (issue_cnt < (ROW_W+1)'(ROWS)) && (!dv || load);
  assign last_load = load && (dv_row == ROW_W'(ROWS - 1));
  assign m_tvalid  = out_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (s_tuser == FUNC_COMPOSE)) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issue_cnt <= '0;
      dv        <= 1'b0;
      dv_row    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        issue_cnt <= '0;
      end else if (issue) begin
        issue_cnt <= issue_cnt + 1'b1;
      end
      if (issue) begin
        dv     <= 1'b1;
        dv_row <= issue_cnt[ROW_W-1:0];
      end else if (load) begin
        dv <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    cmd.wr_en   = accept && (s_tuser == FUNC_WRITE);
    cmd.cap     = accept && (s_tuser == FUNC_COMPOSE);
    cmd.issue   = issue;
    cmd.rd_row  = issue_cnt[ROW_W-1:0];
    cmd.load    = load;
    cmd.out_row = dv_row;
  end

endmodule

>>> src/hgc_datapath.sv
// Datapath of the glyph composer: glyph stores, glyph selection and row merge.
module hgc_datapath (
  input  logic                           clk,
  input  hgc_pkg::hgc_cmd_t              cmd,
  input  logic [hgc_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic [hgc_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                           m_tlast
);
  import hgc_pkg::*;

  logic [15:0] init_mem [INIT_DEPTH];
  logic [15:0] med_mem  [MED_DEPTH];
  logic [15:0] fin_mem  [FIN_DEPTH];

  logic [1:0]  in_sel;
  logic [11:0] in_addr;
  logic [15:0] in_word;
  logic [4:0]  in_f;
  logic [4:0]  in_m;
  logic [4:0]  in_l;

  logic [4:0]  f;
  logic [4:0]  m;
  logic [4:0]  l;
  logic [3:0]  fset;
  logic [1:0]  lset;
  logic [1:0]  mset;
  logic [9:0]  fg;
  logic [9:0]  mg;
  logic [9:0]  lg;

  logic               en_f;
  logic               en_m;
  logic               en_l;
  logic [INIT_GW-1:0] fbase;
  logic [MED_GW-1:0]  mbase;
  logic [FIN_GW-1:0]  lbase;
  logic [4:0]         advance;

  logic [15:0] rd_f;
  logic [15:0] rd_m;
  logic [15:0] rd_l;
  logic [15:0] merged;

  logic [ROW_W-1:0] out_row;
  logic [15:0]      out_bits;
  logic [4:0]       out_adv;
  logic             out_last;

  assign in_sel  = s_tdata[1:0];
  assign in_addr = s_tdata[13:2];
  assign in_word = s_tdata[29:14];
  assign in_f    = s_tdata[34:30];
  assign in_m    = s_tdata[39:35];
  assign in_l    = s_tdata[44:40];

  // Glyph numbers of the three parts for a compose request.
  always_comb begin
    f    = (in_f > INIT_CODES) ? 5'd0 : in_f;
    m    = (in_m > MED_CODES)  ? 5'd0 : in_m;
    l    = (in_l > FIN_CODES)  ? 5'd0 : in_l;
    fset = {1'b0, init_set(m)};
    lset = fin_set(m);
    mset = ((f == 5'd1) || (f == 5'd16)) ? 2'd0 : 2'd1;
    if (l != 5'd0) begin
      fset = fset + 4'd5;
      mset = mset + 2'd2;
    end
    fg = 10'(f) + 10'(fset) * 10'(INIT_CODES) - 10'd1;
    mg = 10'(m) + 10'(mset) * 10'(MED_CODES) - 10'd1;
    lg = 10'(l) + 10'(lset) * 10'(FIN_CODES) - 10'd1;
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      en_f    <= (f != 5'd0) && (fg < 10'(INITIAL_GLYPHS));
      en_m    <= (m != 5'd0) && (mg < 10'(MEDIAL_GLYPHS));
      en_l    <= (l != 5'd0) && (lg < 10'(FINAL_GLYPHS));
      fbase   <= fg[INIT_GW-1:0];
      mbase   <= mg[MED_GW-1:0];
      lbase   <= lg[FIN_GW-1:0];
      advance <= ((f == 5'd0) && (m == 5'd0) && (l == 5'd0)) ? ADV_NARROW : ADV_WIDE;
    end
  end

  // Row writes; a write beyond the depth of its store is dropped.
  always_ff @(posedge clk) begin
    if (cmd.wr_en && (in_sel == STORE_INITIAL) && ({1'b0, in_addr} < 13'(INIT_DEPTH))) begin
      init_mem[in_addr[INIT_AW-1:0]] <= in_word;
    end
    if (cmd.wr_en && (in_sel == STORE_MEDIAL) && ({1'b0, in_addr} < 13'(MED_DEPTH))) begin
      med_mem[in_addr[MED_AW-1:0]] <= in_word;
    end
    if (cmd.wr_en && (in_sel == STORE_FINAL) && ({1'b0, in_addr} < 13'(FIN_DEPTH))) begin
      fin_mem[in_addr[FIN_AW-1:0]] <= in_word;
    end
  end

  // Registered reads of one row from each store.
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_f <= init_mem[{fbase, cmd.rd_row}];
      rd_m <= med_mem[{mbase, cmd.rd_row}];
      rd_l <= fin_mem[{lbase, cmd.rd_row}];
    end
  end

  assign merged = (en_f ? rd_f : 16'h0000) | (en_m ? rd_m : 16'h0000)
                | (en_l ? rd_l : 16'h0000);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_row  <= cmd.out_row;
      out_bits <= merged;
      out_adv  <= advance;
      out_last <= (cmd.out_row == ROW_W'(ROWS - 1));
    end
  end

  assign m_tdata = {7'd0, out_adv, out_bits, out_row};
  assign m_tlast = out_last;

endmodule

>>> src/hangul_glyph_composer.sv
// Top level of the 16x16 Hangul glyph composer.
// A row write request returns nothing. A compose request yields sixteen rows, one row a cycle
// while the output is taken; the three store read ports set that pace. The controller enters its
// run state, then each row passes the registered store reads and the output register.
// A new request can be accepted in the same cycle that the sixteenth row enters the output register.
// Reset clears the controller and output valid only; the glyph stores hold no defined contents.
module hangul_glyph_composer (
  input  logic                           clk,
  input  logic                           rst,
  // Request channel.
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // s_tdata, lowest bit up: store_select[1:0], word_address[13:2], word_data[29:14],
  // initial_code[34:30], medial_code[39:35], final_code[44:40], zero fill [47:45]
  input  logic [hgc_pkg::IN_DATA_W-1:0]  s_tdata,
  // s_tuser: func, 0 writes a row word, 1 composes a glyph
  input  logic                           s_tuser,
  // Row channel.
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // m_tdata, lowest bit up: row_index[3:0], row_bits[19:4], advance[24:20], zero fill [31:25]
  output logic [hgc_pkg::OUT_DATA_W-1:0] m_tdata,
  // m_tlast: last_row, high on the sixteenth row of a glyph
  output logic                           m_tlast
);
  import hgc_pkg::*;

  hgc_cmd_t cmd;

  // The controller accepts requests only when no glyph is being read out; the output
  // register lets the final row wait for the sink while the next request comes in.
  hgc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // The datapath holds the three stores, works out glyph numbers when a compose request
  // is captured, and merges the masked rows into the output register.
  hgc_datapath u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .s_tdata (s_tdata),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

endmodule

>>> src/hgc_checker.sv
// Port-level checker of the glyph composer and its bind to the top level.
module hgc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);

  // A stalled row stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("row withdrawn while stalled");

  // The last-row flag goes with row fifteen and no other.
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[3:0] == 4'hf)))
    else $error("last row flag does not match row index");

  // Advance is either narrow or wide.
  a_adv: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[24:20] == 5'd8) || (m_tdata[24:20] == 5'd16))
    else $error("advance out of range");

  // A narrow glyph has every part masked, so its rows are blank.
  a_blank: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[24:20] == 5'd8) |-> (m_tdata[19:4] == 16'h0000))
    else $error("narrow glyph with pixels set");

  // A compose request keeps the block busy on the following cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> !s_tready)
    else $error("request taken straight after a compose request");

endmodule

bind hangul_glyph_composer hgc_checker u_hgc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
